// ===== design/acqm_pkg.sv =====
package acqm_pkg;

	localparam int WINDOW_LEN_DEF = 8;
	localparam int CHANNELS_DEF = 32;
	localparam int POOL_SIZE_DEF = 64;

	localparam int FREQ_LIMIT = 64;
	localparam int SUM_MAX = 2047;
	localparam int UNDEC_MAX = 15;

	localparam int FIRST_RST = 32;
	localparam int TOTAL_RST = 64;
	localparam int NEED_RST = 8;

	localparam logic [1:0] CFG_FIRST = 2'd0;
	localparam logic [1:0] CFG_TOTAL = 2'd1;
	localparam logic [1:0] CFG_NEED = 2'd2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_QUERY = 3'd1,
		OP_REPL_FIRST = 3'd2,
		OP_REPL_NAMED = 3'd3,
		OP_CLEAR = 3'd4,
		OP_REBUILD = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GO,
		ST_WIN,
		ST_POOL,
		ST_OUT
	} st_t;

	typedef enum logic [1:0] {
		P_IDLE,
		P_SCAN,
		P_MOVE,
		P_FIN
	} pool_st_t;

	typedef struct packed {
		logic start;
		logic query;
		logic clr_samples;
		logic clr_clean;
		logic clr_all;
	} win_cmd_t;

	typedef struct packed {
		logic start;
		logic rebuild;
		logic pop_first;
		logic find;
	} pool_cmd_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic [10:0] error_sum;
		logic [10:0] limit_sum;
		logic [3:0] undecoded_count;
		logic reject_flag;
		logic stats_valid;
		logic window_clean;
	} win_res_t;

	typedef struct packed {
		logic pool_empty;
		logic [6:0] pool_position;
		logic [5:0] new_freq;
		logic window_clean;
		logic stats_valid;
		logic reject_flag;
		logic [3:0] undecoded_count;
		logic [10:0] limit_sum;
		logic [10:0] error_sum;
	} res_t;

endpackage

// ===== design/acqm_cell.sv =====
module acqm_cell #(
	parameter logic [5:0] RST_VAL = '0
) (
	input logic clk,
	input logic arst_n,
	input acqm_pkg::cell_ctl_t ctl,
	input logic [5:0] ld_val,
	input logic [5:0] nxt,
	output logic [5:0] val
);

	logic [5:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= RST_VAL;
		end else if (ctl.load) begin
			val_q <= ld_val;
		end else if (ctl.shift) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule

// ===== design/acqm_pool.sv =====
module acqm_pool #(
	parameter int POOL_SIZE = acqm_pkg::POOL_SIZE_DEF,
	localparam int PW = $clog2(POOL_SIZE),
	localparam int CW = $clog2(POOL_SIZE + 1)
) (
	input logic clk,
	input logic arst_n,
	input acqm_pkg::pool_cmd_t cmd,
	input logic [5:0] oldf,
	input logic [5:0] want,
	input logic [5:0] first,
	input logic [6:0] total,
	output logic done,
	output logic found,
	output logic [6:0] pos,
	output logic [5:0] head,
	output logic empty
);

	localparam int RST_END = (acqm_pkg::TOTAL_RST > acqm_pkg::FREQ_LIMIT) ?
		acqm_pkg::FREQ_LIMIT : acqm_pkg::TOTAL_RST;
	localparam int RST_SPAN = (acqm_pkg::FIRST_RST < RST_END) ?
		RST_END - acqm_pkg::FIRST_RST : 0;
	localparam int RST_N = (RST_SPAN > POOL_SIZE) ? POOL_SIZE : RST_SPAN;

	logic [5:0] vals [POOL_SIZE];
	logic [5:0] ldv [POOL_SIZE];
	acqm_pkg::cell_ctl_t ctl [POOL_SIZE];
	acqm_pkg::pool_st_t st_q, st_d;
	logic [CW-1:0] cnt_q, idx_q, cnt_rb;
	logic [PW-1:0] pos_q;
	logic found_q, empty_q, hit;
	logic [5:0] head_q;
	logic [6:0] end_f, span;

	for (genvar g = 0; g < POOL_SIZE; g++) begin : g_row
		acqm_cell #(
			.RST_VAL(6'((acqm_pkg::FIRST_RST + g) % 64))
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl[g]),
			.ld_val(ldv[g]),
			.nxt(vals[(g + 1 < POOL_SIZE) ? g + 1 : g]),
			.val(vals[g])
		);
	end

	always_comb begin
		end_f = (total > 7'(acqm_pkg::FREQ_LIMIT)) ? 7'(acqm_pkg::FREQ_LIMIT) : total;
		span = ({1'b0, first} < end_f) ? end_f - {1'b0, first} : '0;
		cnt_rb = (32'(span) > POOL_SIZE) ? CW'(POOL_SIZE) : CW'(span);
		hit = (idx_q != cnt_q) && (vals[idx_q[PW-1:0]] == want);
		st_d = st_q;
		case (st_q)
			acqm_pkg::P_IDLE: begin
				if (cmd.start) begin
					if (cmd.rebuild) begin
						st_d = acqm_pkg::P_FIN;
					end else if (cmd.pop_first) begin
						st_d = (cnt_q == '0) ? acqm_pkg::P_FIN : acqm_pkg::P_MOVE;
					end else if (cmd.find) begin
						st_d = acqm_pkg::P_SCAN;
					end
				end
			end
			acqm_pkg::P_SCAN: begin
				if (idx_q == cnt_q) begin
					st_d = acqm_pkg::P_FIN;
				end else if (hit) begin
					st_d = acqm_pkg::P_MOVE;
				end
			end
			acqm_pkg::P_MOVE: st_d = acqm_pkg::P_FIN;
			acqm_pkg::P_FIN: st_d = acqm_pkg::P_IDLE;
			default: st_d = acqm_pkg::P_IDLE;
		endcase
		for (int i = 0; i < POOL_SIZE; i++) begin
			ctl[i].load = (st_q == acqm_pkg::P_IDLE && cmd.start && cmd.rebuild) ||
				(st_q == acqm_pkg::P_MOVE && i == 32'(cnt_q) - 1);
			ctl[i].shift = (st_q == acqm_pkg::P_MOVE) && (i >= 32'(pos_q)) &&
				(i + 1 < 32'(cnt_q));
			ldv[i] = (st_q == acqm_pkg::P_MOVE) ? oldf : 6'(32'(first) + i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= acqm_pkg::P_IDLE;
			cnt_q <= CW'(RST_N);
			idx_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			empty_q <= 1'b0;
			head_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == acqm_pkg::P_IDLE && cmd.start) begin
				found_q <= 1'b0;
				empty_q <= 1'b0;
				idx_q <= '0;
				pos_q <= '0;
				if (cmd.rebuild) begin
					cnt_q <= cnt_rb;
				end
				if (cmd.pop_first) begin
					if (cnt_q == '0) begin
						empty_q <= 1'b1;
					end else begin
						found_q <= 1'b1;
						head_q <= vals[0];
					end
				end
			end
			if (st_q == acqm_pkg::P_SCAN) begin
				if (hit) begin
					found_q <= 1'b1;
					pos_q <= idx_q[PW-1:0];
				end else if (idx_q != cnt_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign done = (st_q == acqm_pkg::P_FIN);
	assign found = found_q;
	assign pos = found_q ? 7'(pos_q) : 7'h7F;
	assign head = head_q;
	assign empty = empty_q;

endmodule

// ===== design/acqm_win.sv =====
module acqm_win #(
	parameter int WINDOW_LEN = acqm_pkg::WINDOW_LEN_DEF,
	parameter int CHANNELS = acqm_pkg::CHANNELS_DEF,
	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input logic clk,
	input logic arst_n,
	input acqm_pkg::win_cmd_t cmd,
	input logic [CHW-1:0] ch,
	input logic [7:0] err,
	input logic [7:0] lim,
	input logic [3:0] need,
	output logic done,
	output acqm_pkg::win_res_t res
);

	localparam int SW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FW = $clog2(WINDOW_LEN + 1);
	localparam int DEPTH = CHANNELS * WINDOW_LEN;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_W = $clog2(255 * WINDOW_LEN + 1);

	logic [7:0] emem [DEPTH];
	logic [7:0] lmem [DEPTH];
	logic [7:0] cmem [DEPTH];
	logic [FW-1:0] wfill_q [CHANNELS];
	logic [FW-1:0] cfill_q [CHANNELS];
	logic [SW-1:0] whead_q [CHANNELS];
	logic [SW-1:0] chead_q [CHANNELS];
	logic busy_q, qry_q, sv_q, nz_q, rv_s1;
	logic [FW-1:0] n_q, rd_q, nd_q, wf_nx, cf_nx;
	logic [CHW-1:0] chb_q;
	logic [ACC_W-1:0] es_q, ls_q;
	logic [7:0] ed_s1, ld_s1, cd_s1;
	logic [AW-1:0] wa, ca, ra;
	logic [SW-1:0] wh_nx, ch_nx;
	logic add_go, issue;

	always_comb begin
		add_go = cmd.start && !cmd.query;
		issue = busy_q && (rd_q < n_q);
		wa = AW'(32'(ch) * WINDOW_LEN + 32'(whead_q[ch]));
		ca = AW'(32'(ch) * WINDOW_LEN + 32'(chead_q[ch]));
		ra = AW'(32'(chb_q) * WINDOW_LEN + 32'(rd_q));
		wh_nx = (32'(whead_q[ch]) == WINDOW_LEN - 1) ? '0 : whead_q[ch] + 1'b1;
		ch_nx = (32'(chead_q[ch]) == WINDOW_LEN - 1) ? '0 : chead_q[ch] + 1'b1;
		wf_nx = (32'(wfill_q[ch]) == WINDOW_LEN) ? wfill_q[ch] : wfill_q[ch] + 1'b1;
		cf_nx = (32'(cfill_q[ch]) == WINDOW_LEN) ? cfill_q[ch] : cfill_q[ch] + 1'b1;
		done = busy_q && !issue && !rv_s1;
		res.error_sum = (32'(es_q) > acqm_pkg::SUM_MAX) ? 11'(acqm_pkg::SUM_MAX) : 11'(es_q);
		res.limit_sum = (32'(ls_q) > acqm_pkg::SUM_MAX) ? 11'(acqm_pkg::SUM_MAX) : 11'(ls_q);
		res.undecoded_count = (32'(nd_q) > acqm_pkg::UNDEC_MAX) ?
			4'(acqm_pkg::UNDEC_MAX) : 4'(nd_q);
		res.reject_flag = (32'(nd_q) >= WINDOW_LEN);
		res.stats_valid = sv_q;
		res.window_clean = !nz_q;
	end

	always_ff @(posedge clk) begin
		if (add_go) begin
			emem[wa] <= err;
			lmem[wa] <= lim;
			cmem[ca] <= err;
		end
		if (issue) begin
			ed_s1 <= emem[ra];
			ld_s1 <= lmem[ra];
			cd_s1 <= cmem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wfill_q[i] <= '0;
				cfill_q[i] <= '0;
				whead_q[i] <= '0;
				chead_q[i] <= '0;
			end
			busy_q <= 1'b0;
			qry_q <= 1'b0;
			sv_q <= 1'b0;
			nz_q <= 1'b0;
			rv_s1 <= 1'b0;
			n_q <= '0;
			rd_q <= '0;
			nd_q <= '0;
			chb_q <= '0;
			es_q <= '0;
			ls_q <= '0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				rd_q <= rd_q + 1'b1;
			end
			if (rv_s1) begin
				es_q <= es_q + ACC_W'(qry_q ? cd_s1 : ed_s1);
				ls_q <= ls_q + ACC_W'(ld_s1);
				if (ed_s1 >= ld_s1) begin
					nd_q <= nd_q + 1'b1;
				end
				if (cd_s1 != 8'd0) begin
					nz_q <= 1'b1;
				end
			end
			if (done) begin
				busy_q <= 1'b0;
			end
			if (cmd.start) begin
				busy_q <= 1'b1;
				qry_q <= cmd.query;
				chb_q <= ch;
				rd_q <= '0;
				es_q <= '0;
				ls_q <= '0;
				nd_q <= '0;
				nz_q <= 1'b0;
				if (cmd.query) begin
					n_q <= cfill_q[ch];
					sv_q <= (32'(wfill_q[ch]) >= WINDOW_LEN) &&
						(32'(cfill_q[ch]) >= 32'(need));
				end else begin
					n_q <= wf_nx;
					whead_q[ch] <= wh_nx;
					wfill_q[ch] <= wf_nx;
					chead_q[ch] <= ch_nx;
					cfill_q[ch] <= cf_nx;
				end
			end
			if (cmd.clr_samples) begin
				wfill_q[ch] <= '0;
				whead_q[ch] <= '0;
			end
			if (cmd.clr_clean) begin
				cfill_q[ch] <= '0;
				chead_q[ch] <= '0;
			end
			if (cmd.clr_all) begin
				for (int i = 0; i < CHANNELS; i++) begin
					wfill_q[i] <= '0;
					whead_q[i] <= '0;
				end
			end
		end
	end

endmodule

// ===== design/adaptive_channel_quality_manager_unit.sv =====
// Channel quality manager. Commands arrive on the s_ stream, one per transaction, and each
// command yields exactly one result transaction on the m_ stream. Configuration registers
// are written through the cfg_ channel, which is always ready and should only be used
// while no command is in flight.
// One command is processed at a time. A sample add or a query walks the channel window
// in the window memories one entry per cycle. A named replace scans the row of pool cells
// one cell per cycle until it finds the wanted frequency or reaches the pool count.
// Replace first, rebuild, a clear and an unused opcode need no scan.
// The pool shifts and appends in the same cycle because every cell takes its neighbor.
// Reset clears all window fill counts and heads and loads the pool cells with the
// ascending default range, so the block accepts a command in the first cycle after reset.
// The result waits in an output register while the receiver stalls; a new command is
// accepted in the meantime, and its result is held back until the register is free.
module adaptive_channel_quality_manager_unit #(
	parameter int WINDOW_LEN = acqm_pkg::WINDOW_LEN_DEF,
	parameter int CHANNELS = acqm_pkg::CHANNELS_DEF,
	parameter int POOL_SIZE = acqm_pkg::POOL_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// opcode, channel, error_count, error_limit, old_freq, wanted_freq, zero pad
	input logic [39:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// error_sum, limit_sum, undecoded_count, reject_flag, stats_valid, window_clean,
	// new_freq, pool_position, pool_empty, zero pad
	output logic [47:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [6:0] cfg_data
);

	localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	acqm_pkg::st_t st_q, st_d;
	acqm_pkg::op_t op_q;
	logic [4:0] ch_q;
	logic [7:0] err_q, lim_q;
	logic [5:0] oldf_q, want_q;
	logic [5:0] first_q;
	logic [6:0] total_q;
	logic [3:0] need_q;
	acqm_pkg::res_t res_q;
	logic [47:0] m_tdata_q;
	logic m_tvalid_q;
	acqm_pkg::win_cmd_t win_cmd;
	acqm_pkg::win_res_t win_res;
	acqm_pkg::pool_cmd_t pool_cmd;
	logic win_done, pool_done, pool_found, pool_empty;
	logic [6:0] pool_pos;
	logic [5:0] pool_head;
	logic ch_ok, set_dflt, take_win, take_pool, load_out;

	acqm_win #(
		.WINDOW_LEN(WINDOW_LEN),
		.CHANNELS(CHANNELS)
	) u_win (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(win_cmd),
		.ch(CHW'(ch_q)),
		.err(err_q),
		.lim(lim_q),
		.need(need_q),
		.done(win_done),
		.res(win_res)
	);

	acqm_pool #(
		.POOL_SIZE(POOL_SIZE)
	) u_pool (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(pool_cmd),
		.oldf(oldf_q),
		.want(want_q),
		.first(first_q),
		.total(total_q),
		.done(pool_done),
		.found(pool_found),
		.pos(pool_pos),
		.head(pool_head),
		.empty(pool_empty)
	);

	assign s_tready = (st_q == acqm_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_comb begin
		ch_ok = (32'(ch_q) < CHANNELS);
		st_d = st_q;
		win_cmd = '0;
		pool_cmd = '0;
		set_dflt = 1'b0;
		take_win = 1'b0;
		take_pool = 1'b0;
		load_out = 1'b0;
		case (st_q)
			acqm_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					st_d = acqm_pkg::ST_GO;
				end
			end
			acqm_pkg::ST_GO: begin
				set_dflt = 1'b1;
				st_d = acqm_pkg::ST_OUT;
				case (op_q)
					acqm_pkg::OP_ADD, acqm_pkg::OP_QUERY: begin
						if (ch_ok) begin
							win_cmd.start = 1'b1;
							win_cmd.query = (op_q == acqm_pkg::OP_QUERY);
							st_d = acqm_pkg::ST_WIN;
						end
					end
					acqm_pkg::OP_REPL_FIRST: begin
						if (ch_ok) begin
							pool_cmd.start = 1'b1;
							pool_cmd.pop_first = 1'b1;
							st_d = acqm_pkg::ST_POOL;
						end
					end
					acqm_pkg::OP_REPL_NAMED: begin
						if (ch_ok) begin
							pool_cmd.start = 1'b1;
							pool_cmd.find = 1'b1;
							st_d = acqm_pkg::ST_POOL;
						end
					end
					acqm_pkg::OP_CLEAR: begin
						if (ch_ok) begin
							win_cmd.clr_samples = 1'b1;
							win_cmd.clr_clean = 1'b1;
						end
					end
					acqm_pkg::OP_REBUILD: begin
						win_cmd.clr_all = 1'b1;
						pool_cmd.start = 1'b1;
						pool_cmd.rebuild = 1'b1;
						st_d = acqm_pkg::ST_POOL;
					end
					default: st_d = acqm_pkg::ST_OUT;
				endcase
			end
			acqm_pkg::ST_WIN: begin
				if (win_done) begin
					take_win = 1'b1;
					st_d = acqm_pkg::ST_OUT;
				end
			end
			acqm_pkg::ST_POOL: begin
				if (pool_done) begin
					take_pool = 1'b1;
					if (pool_found && op_q != acqm_pkg::OP_REBUILD) begin
						win_cmd.clr_samples = 1'b1;
					end
					st_d = acqm_pkg::ST_OUT;
				end
			end
			acqm_pkg::ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					st_d = acqm_pkg::ST_IDLE;
				end
			end
			default: st_d = acqm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= acqm_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			first_q <= 6'(acqm_pkg::FIRST_RST);
			total_q <= 7'(acqm_pkg::TOTAL_RST);
			need_q <= 4'(acqm_pkg::NEED_RST);
		end else begin
			st_q <= st_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					acqm_pkg::CFG_FIRST: first_q <= cfg_data[5:0];
					acqm_pkg::CFG_TOTAL: total_q <= cfg_data;
					acqm_pkg::CFG_NEED: need_q <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q <= acqm_pkg::op_t'(s_tdata[2:0]);
			ch_q <= s_tdata[7:3];
			err_q <= s_tdata[15:8];
			lim_q <= s_tdata[23:16];
			oldf_q <= s_tdata[29:24];
			want_q <= s_tdata[35:30];
		end
		if (set_dflt) begin
			res_q <= '{pool_position: 7'h7F, default: '0};
		end
		if (take_win) begin
			if (op_q == acqm_pkg::OP_ADD) begin
				res_q.error_sum <= win_res.error_sum;
				res_q.limit_sum <= win_res.limit_sum;
				res_q.undecoded_count <= win_res.undecoded_count;
				res_q.reject_flag <= win_res.reject_flag;
			end else begin
				res_q.stats_valid <= win_res.stats_valid;
				res_q.window_clean <= win_res.window_clean;
			end
		end
		if (take_pool) begin
			if (op_q == acqm_pkg::OP_REPL_FIRST) begin
				res_q.new_freq <= pool_found ? pool_head : 6'd0;
				res_q.pool_empty <= pool_empty;
			end else if (op_q == acqm_pkg::OP_REPL_NAMED) begin
				res_q.pool_position <= pool_pos;
			end
		end
		if (load_out) begin
			m_tdata_q <= {5'd0, res_q};
		end
	end

endmodule

// ===== design/acqm_chk.sv =====
module acqm_chk (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [39:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [47:0] m_tdata,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [6:0] cfg_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled result transaction changed.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Command accepted while another is in flight.");

	a_empty_freq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[42] && m_tdata[34:29] != 6'd0))
		else $error("Empty pool reported together with a frequency.");

	a_reject_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[26] |-> m_tdata[25:22] != 4'd0)
		else $error("Reject flag raised without undecoded entries.");

endmodule

bind adaptive_channel_quality_manager_unit acqm_chk u_acqm_chk (.*);

// ===== dv/tb_adaptive_channel_quality_manager_unit.sv =====
`timescale 1ns / 100ps

class quality_scoreboard;
	bit [7:0] err_win[256];
	bit [7:0] lim_win[256];
	bit [7:0] cln_win[256];
	int unsigned win_fill[32];
	int unsigned win_head[32];
	int unsigned cln_fill[32];
	int unsigned cln_head[32];
	bit [5:0] pool[64];
	int unsigned pool_cnt;
	int unsigned first_freq;
	int unsigned total_freq;
	int unsigned need;
	acqm_pkg::res_t expected_q[$];
	int errors;
	int checked;
	int op_seen[8];
	int empty_hits;
	int named_misses;
	int rejects;

	function new();
		first_freq = acqm_pkg::FIRST_RST;
		total_freq = acqm_pkg::TOTAL_RST;
		need = acqm_pkg::NEED_RST;
		foreach (win_fill[c]) begin
			win_fill[c] = 0;
			win_head[c] = 0;
			cln_fill[c] = 0;
			cln_head[c] = 0;
		end
		rebuild_pool();
	endfunction

	function void write_register(logic [1:0] idx, logic [6:0] val);
		if (idx == acqm_pkg::CFG_FIRST) first_freq = 32'(val[5:0]);
		else if (idx == acqm_pkg::CFG_TOTAL) total_freq = 32'(val);
		else if (idx == acqm_pkg::CFG_NEED) need = 32'(val[3:0]);
	endfunction

	function void rebuild_pool();
		int unsigned stop;
		stop = (total_freq > acqm_pkg::FREQ_LIMIT) ? acqm_pkg::FREQ_LIMIT : total_freq;
		pool_cnt = 0;
		for (int unsigned f = first_freq; f < stop && pool_cnt < 64; f++) begin
			pool[pool_cnt] = f[5:0];
			pool_cnt++;
		end
	endfunction

	function void pool_take(int unsigned pos, bit [5:0] retired);
		for (int unsigned i = pos; i + 1 < pool_cnt; i++) pool[i] = pool[i + 1];
		pool_cnt--;
		if (pool_cnt < 64) begin
			pool[pool_cnt] = retired;
			pool_cnt++;
		end
	endfunction

	function void note_command(logic [39:0] cmd);
		logic [2:0] opc;
		int unsigned ch;
		int unsigned base;
		int unsigned es;
		int unsigned ls;
		int unsigned nd;
		int unsigned s;
		acqm_pkg::res_t r;
		opc = cmd[2:0];
		ch = 32'(cmd[7:3]);
		base = ch * 8;
		r = '0;
		r.pool_position = 7'h7F;
		op_seen[opc]++;
		if (opc == acqm_pkg::OP_ADD) begin
			err_win[base + win_head[ch]] = cmd[15:8];
			lim_win[base + win_head[ch]] = cmd[23:16];
			win_head[ch] = (win_head[ch] + 1) % 8;
			if (win_fill[ch] < 8) win_fill[ch]++;
			cln_win[base + cln_head[ch]] = cmd[15:8];
			cln_head[ch] = (cln_head[ch] + 1) % 8;
			if (cln_fill[ch] < 8) cln_fill[ch]++;
			es = 0;
			ls = 0;
			nd = 0;
			for (int unsigned i = 0; i < win_fill[ch]; i++) begin
				es += 32'(err_win[base + i]);
				ls += 32'(lim_win[base + i]);
				if (err_win[base + i] >= lim_win[base + i]) nd++;
			end
			r.error_sum = (es > acqm_pkg::SUM_MAX) ? 11'(acqm_pkg::SUM_MAX) : 11'(es);
			r.limit_sum = (ls > acqm_pkg::SUM_MAX) ? 11'(acqm_pkg::SUM_MAX) : 11'(ls);
			r.undecoded_count = (nd > acqm_pkg::UNDEC_MAX) ?
				4'(acqm_pkg::UNDEC_MAX) : 4'(nd);
			r.reject_flag = (nd >= 8);
			if (nd >= 8) rejects++;
		end else if (opc == acqm_pkg::OP_QUERY) begin
			s = 0;
			for (int unsigned i = 0; i < cln_fill[ch]; i++) s += 32'(cln_win[base + i]);
			r.stats_valid = (win_fill[ch] >= 8 && cln_fill[ch] >= need);
			r.window_clean = (s == 0);
		end else if (opc == acqm_pkg::OP_REPL_FIRST) begin
			if (pool_cnt == 0) begin
				r.pool_empty = 1'b1;
				empty_hits++;
			end else begin
				r.new_freq = pool[0];
				pool_take(0, cmd[29:24]);
				win_fill[ch] = 0;
				win_head[ch] = 0;
			end
		end else if (opc == acqm_pkg::OP_REPL_NAMED) begin
			named_misses++;
			for (int unsigned i = 0; i < pool_cnt; i++) begin
				if (pool[i] == cmd[35:30]) begin
					r.pool_position = 7'(i);
					pool_take(i, cmd[29:24]);
					win_fill[ch] = 0;
					win_head[ch] = 0;
					named_misses--;
					break;
				end
			end
		end else if (opc == acqm_pkg::OP_CLEAR) begin
			win_fill[ch] = 0;
			win_head[ch] = 0;
			cln_fill[ch] = 0;
			cln_head[ch] = 0;
		end else if (opc == acqm_pkg::OP_REBUILD) begin
			foreach (win_fill[c]) begin
				win_fill[c] = 0;
				win_head[c] = 0;
			end
			rebuild_pool();
		end
		expected_q.push_back(r);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_result(logic [47:0] d);
		acqm_pkg::res_t e;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %h", $time, d);
			return;
		end
		e = expected_q.pop_front();
		checked++;
		compare_field("error_sum", 32'(e.error_sum), 32'(d[10:0]));
		compare_field("limit_sum", 32'(e.limit_sum), 32'(d[21:11]));
		compare_field("undecoded_count", 32'(e.undecoded_count), 32'(d[25:22]));
		compare_field("reject_flag", 32'(e.reject_flag), 32'(d[26]));
		compare_field("stats_valid", 32'(e.stats_valid), 32'(d[27]));
		compare_field("window_clean", 32'(e.window_clean), 32'(d[28]));
		compare_field("new_freq", 32'(e.new_freq), 32'(d[34:29]));
		compare_field("pool_position", 32'(e.pool_position), 32'(d[41:35]));
		compare_field("pool_empty", 32'(e.pool_empty), 32'(d[42]));
		compare_field("pad", 0, 32'(d[47:43]));
	endfunction
endclass

module tb_adaptive_channel_quality_manager_unit;
	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [39:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;

	int idle_pct;
	int stall_pct;
	quality_scoreboard sb;

	adaptive_channel_quality_manager_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(10 * 2000000);
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [39:0] pack_command(logic [2:0] opc, logic [4:0] ch,
			logic [7:0] err, logic [7:0] lim, logic [5:0] oldf, logic [5:0] want);
		return {4'b0, want, oldf, lim, err, ch, opc};
	endfunction

	function automatic logic [39:0] random_command();
		int unsigned pick;
		logic [2:0] opc;
		logic [4:0] ch;
		logic [7:0] err;
		logic [7:0] lim;
		logic [5:0] want;
		pick = $urandom_range(99);
		if (pick < 42) opc = acqm_pkg::OP_ADD;
		else if (pick < 58) opc = acqm_pkg::OP_QUERY;
		else if (pick < 68) opc = acqm_pkg::OP_REPL_FIRST;
		else if (pick < 84) opc = acqm_pkg::OP_REPL_NAMED;
		else if (pick < 91) opc = acqm_pkg::OP_CLEAR;
		else if (pick < 96) opc = acqm_pkg::OP_REBUILD;
		else opc = 3'($urandom_range(7, 6));
		ch = ($urandom_range(99) < 75) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
		lim = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 30) err = 8'd0;
		else if (pick < 60) err = 8'($urandom_range(255, 32'(lim)));
		else err = 8'($urandom_range(255));
		if (sb.pool_cnt > 0 && $urandom_range(99) < 75)
			want = sb.pool[$urandom_range(sb.pool_cnt - 1)];
		else
			want = 6'($urandom_range(63));
		return pack_command(opc, ch, err, lim, 6'($urandom_range(63)), want);
	endfunction

	task automatic send_command(logic [39:0] cmd);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cmd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(cmd);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_register(idx, val);
	endtask

	task automatic configure(logic [6:0] first, logic [6:0] total, logic [6:0] needed);
		write_register(acqm_pkg::CFG_FIRST, first);
		write_register(acqm_pkg::CFG_TOTAL, total);
		write_register(acqm_pkg::CFG_NEED, needed);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) drain();
			send_command(random_command());
		end
		drain();
	endtask

	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(pack_command(acqm_pkg::OP_QUERY, 5'd31, 8'd0, 8'd0, 6'd0, 6'd0));
		for (int i = 0; i < 9; i++)
			send_command(pack_command(acqm_pkg::OP_ADD, 5'd0, 8'd255, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_QUERY, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_ADD, 5'd1, 8'd0, 8'd255, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_QUERY, 5'd1, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_REPL_FIRST, 5'd0, 8'd0, 8'd0, 6'd63, 6'd0));
		send_command(pack_command(acqm_pkg::OP_REPL_NAMED, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_REPL_NAMED, 5'd1, 8'd0, 8'd0, 6'd1, 6'd63));
		send_command(pack_command(acqm_pkg::OP_CLEAR, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_QUERY, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(3'd6, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(3'd7, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_REBUILD, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		drain();

		// An inverted range leaves the pool empty after a rebuild.
		configure(7'd63, 7'd10, 7'd1);
		send_command(pack_command(acqm_pkg::OP_REBUILD, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_REPL_FIRST, 5'd2, 8'd0, 8'd0, 6'd5, 6'd0));
		send_command(pack_command(acqm_pkg::OP_REPL_NAMED, 5'd2, 8'd0, 8'd0, 6'd5, 6'd63));
		send_command(pack_command(acqm_pkg::OP_ADD, 5'd2, 8'd0, 8'd1, 6'd0, 6'd0));
		send_command(pack_command(acqm_pkg::OP_QUERY, 5'd2, 8'd0, 8'd0, 6'd0, 6'd0));
		drain();

		configure(7'd0, 7'd127, 7'd8);
		send_command(pack_command(acqm_pkg::OP_REBUILD, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		run_random(110, 0, 0);
		configure(7'd20, 7'd40, 7'd4);
		send_command(pack_command(acqm_pkg::OP_REBUILD, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		run_random(110, 45, 0);
		configure(7'd60, 7'd64, 7'd15);
		run_random(110, 0, 45);
		configure(7'd0, 7'd1, 7'd1);
		send_command(pack_command(acqm_pkg::OP_REBUILD, 5'd0, 8'd0, 8'd0, 6'd0, 6'd0));
		run_random(110, 36, 36);
		repeat (100) @(posedge clk);

		$display("Checked %0d results; adds %0d, queries %0d, replace first %0d, named %0d.",
			sb.checked, sb.op_seen[0], sb.op_seen[1], sb.op_seen[2], sb.op_seen[3]);
		$display("Clears %0d, rebuilds %0d, unused %0d, rejects %0d, empty pool %0d, misses %0d.",
			sb.op_seen[4], sb.op_seen[5], sb.op_seen[6] + sb.op_seen[7], sb.rejects,
			sb.empty_hits, sb.named_misses);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
